FILE: rtl/tgdc_pkg.sv
`timescale 1ns / 1ps

package tgdc_pkg;

    // per-channel phase codes
    localparam logic [1:0] PHASE_IDLE = 2'd0;
    localparam logic [1:0] PHASE_ON   = 2'd1;
    localparam logic [1:0] PHASE_OFF  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_OFF_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_ON_SECONDS    = 2'd1;
    localparam logic [1:0] REG_OFF_SECONDS   = 2'd2;

    // configuration reset values
    localparam logic signed [15:0] OFF_THRESHOLD_RESET = 16'sd0;
    localparam logic [15:0]        ON_SECONDS_RESET    = 16'd180;
    localparam logic [15:0]        OFF_SECONDS_RESET   = 16'd120;

    // stored state of one channel
    typedef struct packed {
        logic [1:0]  phase;
        logic [31:0] start;
        logic        output_on;
    } chan_state_t;

    localparam int STATE_W = $bits(chan_state_t);

    // pin action for one transaction
    typedef struct packed {
        logic write;
        logic on;
    } drive_t;

endpackage

FILE: rtl/tgdc_ram.sv
`timescale 1ns / 1ps

module tgdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/tgdc_step.sv
`timescale 1ns / 1ps

module tgdc_step (
    input  tgdc_pkg::chan_state_t cur_state,
    input  logic                  reading_valid,
    input  logic signed [15:0]    temperature,
    input  logic [31:0]           now_seconds,
    input  logic signed [15:0]    off_threshold,
    input  logic [15:0]           on_seconds,
    input  logic [15:0]           off_seconds,
    output tgdc_pkg::chan_state_t next_state,
    output tgdc_pkg::drive_t      drive
);
    import tgdc_pkg::*;

    logic [31:0] elapsed;
    logic        on_done;
    logic        off_done;

    assign elapsed  = now_seconds - cur_state.start;
    assign on_done  = elapsed >= {16'd0, on_seconds};
    assign off_done = elapsed >= {16'd0, off_seconds};

    always_comb
    begin
        next_state = cur_state;
        drive      = '0;
        if (!reading_valid)
        begin
            // missing reading: force off, back to idle, start kept
            drive.write          = 1'b1;
            next_state.output_on = 1'b0;
            next_state.phase     = PHASE_IDLE;
        end
        else if (temperature < off_threshold)
        begin
            // cool: only an active output is switched off
            if (cur_state.output_on)
            begin
                drive.write          = 1'b1;
                next_state.output_on = 1'b0;
                next_state.phase     = PHASE_IDLE;
            end
        end
        else
        begin
            unique case (cur_state.phase)
                PHASE_IDLE:
                begin
                    next_state.phase     = PHASE_ON;
                    next_state.start     = now_seconds;
                    next_state.output_on = 1'b1;
                    drive.write          = 1'b1;
                    drive.on             = 1'b1;
                end
                PHASE_ON:
                begin
                    if (on_done)
                    begin
                        next_state.phase     = PHASE_OFF;
                        next_state.start     = now_seconds;
                        next_state.output_on = 1'b0;
                        drive.write          = 1'b1;
                    end
                end
                PHASE_OFF:
                begin
                    if (off_done)
                    begin
                        next_state.phase     = PHASE_ON;
                        next_state.start     = now_seconds;
                        next_state.output_on = 1'b1;
                        drive.write          = 1'b1;
                        drive.on             = 1'b1;
                    end
                end
                default:
                begin
                    next_state = cur_state;
                end
            endcase
        end
    end

endmodule

FILE: rtl/threshold_gated_duty_cycle_timer.sv
`timescale 1ns / 1ps

// per-channel on/off cycler gated by a temperature threshold
// input channel: in_valid / in_stall carry one transaction per reading
//   (channel, reading_valid, temperature, now_seconds)
// output channel: out_valid / out_stall return exactly one transaction per
//   input: the echoed channel and the pin action (drive_write, drive_on)
// config channel: cfg_valid / cfg_ready with cfg_index and cfg_data;
//   index 0 off_threshold, 1 on_seconds, 2 off_seconds, other indexes ignored;
//   cfg_ready is always high, write only while the block is idle
// datapath: the accept edge loads the input/state-read register, which moves on
//   into the result register once that register is free or drains
// throughput: one transaction per cycle unless out_stall backs it up, set by
//   the single state ram port pair: read at accept, forwarded write-back on advance
// reset: all channels idle, start time 0, output off, configuration defaults
//   (threshold 0, on 180 s, off 120 s); no clearing pass, per-entry valid bits
// stall: when out_stall holds a full result register, the internal stage
//   fills and then in_stall rises in the same cycle, nothing is dropped
module threshold_gated_duty_cycle_timer #(
    parameter int CHANNELS = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  channel,
    input  logic        reading_valid,
    input  logic signed [15:0] temperature,
    input  logic [31:0] now_seconds,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_channel,
    output logic        drive_write,
    output logic        drive_on,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import tgdc_pkg::*;

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // configuration registers
    logic signed [15:0] off_threshold_reg;
    logic [15:0]        on_seconds_reg;
    logic [15:0]        off_seconds_reg;

    // stage 1: accepted transaction plus state read
    logic               s1_valid_reg;
    logic [7:0]         s1_channel_reg;
    logic               s1_in_range_reg;
    logic               s1_reading_valid_reg;
    logic signed [15:0] s1_temperature_reg;
    logic [31:0]        s1_now_reg;
    logic               s1_entry_valid_reg;
    logic               fwd_hit_reg;
    chan_state_t        fwd_state_reg;

    // result register
    logic               out_valid_reg;
    logic [7:0]         out_channel_reg;
    logic               drive_write_reg;
    logic               drive_on_reg;

    // entry written since reset
    logic [CHANNELS-1:0] entry_valid_reg;

    logic               accept;
    logic               s1_advance;
    logic               in_range;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               wr_en;
    logic [STATE_W-1:0] ram_rd_data;
    chan_state_t        cur_state;
    chan_state_t        next_state;
    drive_t             drive;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_threshold_reg <= OFF_THRESHOLD_RESET;
            on_seconds_reg    <= ON_SECONDS_RESET;
            off_seconds_reg   <= OFF_SECONDS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_OFF_THRESHOLD: off_threshold_reg <= cfg_data;
                REG_ON_SECONDS:    on_seconds_reg    <= cfg_data;
                REG_OFF_SECONDS:   off_seconds_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    // handshake: stage 1 moves on when the result register is free or drains
    assign s1_advance = s1_valid_reg & (~out_valid_reg | ~out_stall);
    assign in_stall   = s1_valid_reg & out_valid_reg & out_stall;
    assign accept     = in_valid & ~in_stall;

    assign in_range = {1'b0, channel} < 9'(CHANNELS);
    assign rd_addr  = channel[AW-1:0];
    assign wr_addr  = s1_channel_reg[AW-1:0];
    // every in-range transaction writes its channel back, changed or not
    assign wr_en    = s1_advance & s1_in_range_reg;

    tgdc_ram #(
        .WIDTH (STATE_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (next_state),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    // a write-back in the same cycle as the read wins over the ram data;
    // entries never written read as the reset state
    always_comb
    begin
        if (fwd_hit_reg)
        begin
            cur_state = fwd_state_reg;
        end
        else if (s1_entry_valid_reg)
        begin
            cur_state = chan_state_t'(ram_rd_data);
        end
        else
        begin
            cur_state = '0;
        end
    end

    tgdc_step u_step (
        .cur_state     (cur_state),
        .reading_valid (s1_reading_valid_reg),
        .temperature   (s1_temperature_reg),
        .now_seconds   (s1_now_reg),
        .off_threshold (off_threshold_reg),
        .on_seconds    (on_seconds_reg),
        .off_seconds   (off_seconds_reg),
        .next_state    (next_state),
        .drive         (drive)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            entry_valid_reg <= '0;
            fwd_hit_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= wr_en & (channel == s1_channel_reg);
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (wr_en)
            begin
                entry_valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_channel_reg       <= channel;
            s1_in_range_reg      <= in_range;
            s1_reading_valid_reg <= reading_valid;
            s1_temperature_reg   <= temperature;
            s1_now_reg           <= now_seconds;
            s1_entry_valid_reg   <= in_range & entry_valid_reg[rd_addr];
            fwd_state_reg        <= next_state;
        end
        if (s1_advance)
        begin
            out_channel_reg <= s1_channel_reg;
            drive_write_reg <= s1_in_range_reg & drive.write;
            drive_on_reg    <= s1_in_range_reg & drive.on;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_channel = out_channel_reg;
    assign drive_write = drive_write_reg;
    assign drive_on    = drive_on_reg;

endmodule

FILE: tb/sv/threshold_gated_duty_cycle_timer_tb.sv
`timescale 1ns / 1ps

module threshold_gated_duty_cycle_timer_tb;

    import tgdc_pkg::*;

    localparam int CHANNELS       = 16;
    localparam int CW             = $clog2(CHANNELS);
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 80;
    localparam int N_SETTINGS     = 6;

    // one reading transaction as it enters the block
    typedef struct packed {
        logic [7:0]         ch;
        logic               ok;
        logic signed [15:0] temp;
        logic [31:0]        now;
    } reading_t;

    // one result transaction: echoed channel and pin action
    typedef struct packed {
        logic [7:0] ch;
        drive_t     pin;
    } action_t;

    // one configuration setting of a stimulus phase
    typedef struct {
        logic signed [15:0] thr;
        logic [15:0]        on_len;
        logic [15:0]        off_len;
        logic [31:0]        t0;
        int                 mode;
    } setting_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic               in_valid      = 1'b0;
    logic               in_stall;
    logic [7:0]         channel       = '0;
    logic               reading_valid = 1'b0;
    logic signed [15:0] temperature   = '0;
    logic [31:0]        now_seconds   = '0;

    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_channel;
    logic       drive_write;
    logic       drive_on;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_OFF_THRESHOLD;
    logic [15:0] cfg_data  = '0;

    // predictor copy of the configuration
    logic signed [15:0] threshold = OFF_THRESHOLD_RESET;
    logic [15:0]        on_len    = ON_SECONDS_RESET;
    logic [15:0]        off_len   = OFF_SECONDS_RESET;

    // predictor copy of the per-channel state
    logic [1:0]  chan_phase [CHANNELS];
    logic [31:0] chan_start [CHANNELS];
    logic        chan_on    [CHANNELS];

    reading_t reading_q [$];   // readings waiting for the driver
    action_t  action_q  [$];   // predicted pin actions, oldest first

    int n_items   = 0;
    int n_results = 0;
    int n_errors  = 0;
    int quiet_cycles = 0;

    // idle percentages, set per stimulus phase
    int src_idle_pct = 21;
    int snk_idle_pct = 79;

    logic in_taken      = 1'b0;
    logic pressure_req  = 1'b0;
    logic pressure_done = 1'b0;
    int   hold_left     = 0;

    // running time base for the random readings
    logic [31:0] clock_now = '0;

    setting_t settings [N_SETTINGS];

    threshold_gated_duty_cycle_timer #(
        .CHANNELS(CHANNELS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .channel       (channel),
        .reading_valid (reading_valid),
        .temperature   (temperature),
        .now_seconds   (now_seconds),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_channel   (out_channel),
        .drive_write   (drive_write),
        .drive_on      (drive_on),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    // predict the pin action of one reading and advance the channel state
    function automatic action_t predict_action(reading_t r);
        action_t       a;
        logic [31:0]   elapsed;
        logic [CW-1:0] ci;
        a.ch        = r.ch;
        a.pin.write = 1'b0;
        a.pin.on    = 1'b0;
        ci          = r.ch[CW-1:0];
        if (r.ch < CHANNELS)
        begin
            // elapsed time wraps modulo 2^32
            elapsed = r.now - chan_start[ci];
            if (!r.ok)
            begin
                // missing reading: force off, back to idle, start time kept
                a.pin.write    = 1'b1;
                chan_on[ci]    = 1'b0;
                chan_phase[ci] = PHASE_IDLE;
            end
            else if ($signed(r.temp) < $signed(threshold))
            begin
                // cool: only an output that is on gets switched off
                if (chan_on[ci])
                begin
                    a.pin.write    = 1'b1;
                    chan_on[ci]    = 1'b0;
                    chan_phase[ci] = PHASE_IDLE;
                end
            end
            else
            begin
                case (chan_phase[ci])
                    PHASE_IDLE:
                    begin
                        chan_phase[ci] = PHASE_ON;
                        chan_start[ci] = r.now;
                        chan_on[ci]    = 1'b1;
                        a.pin.write    = 1'b1;
                        a.pin.on       = 1'b1;
                    end
                    PHASE_ON:
                    begin
                        if (elapsed >= {16'd0, on_len})
                        begin
                            chan_phase[ci] = PHASE_OFF;
                            chan_start[ci] = r.now;
                            chan_on[ci]    = 1'b0;
                            a.pin.write    = 1'b1;
                        end
                    end
                    PHASE_OFF:
                    begin
                        if (elapsed >= {16'd0, off_len})
                        begin
                            chan_phase[ci] = PHASE_ON;
                            chan_start[ci] = r.now;
                            chan_on[ci]    = 1'b1;
                            a.pin.write    = 1'b1;
                            a.pin.on       = 1'b1;
                        end
                    end
                    default: ;  // unused phase code holds and writes nothing
                endcase
            end
        end
        return a;
    endfunction

    // input driver: new reading only when the line is free or just taken
    always @(negedge clk)
    begin : input_driver
        reading_t nxt;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (reading_q.size() > 0 && $urandom_range(99) >= src_idle_pct)
            begin
                nxt = reading_q.pop_front();
                in_valid      <= 1'b1;
                channel       <= nxt.ch;
                reading_valid <= nxt.ok;
                temperature   <= nxt.temp;
                now_seconds   <= nxt.now;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // result receiver: random stalls, plus one long hold-off when asked
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (pressure_req && !pressure_done)
        begin
            // stay stalled long enough for the block to back up into in_stall
            out_stall     <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            pressure_done <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < snk_idle_pct);
        end
    end

    // monitor: predict on input transactions, check output transactions
    always @(posedge clk)
    begin : monitor
        action_t exp_a;
        if (!rst_n)
        begin
            in_taken <= 1'b0;
        end
        else
        begin
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
                action_q.push_back(predict_action({channel, reading_valid,
                                                   temperature, now_seconds}));
            if (out_valid && !out_stall)
            begin
                n_results++;
                if (action_q.size() == 0)
                begin
                    $display("%0t: unexpected result ch %0d write %0b on %0b",
                             $time, out_channel, drive_write, drive_on);
                    n_errors++;
                end
                else
                begin
                    exp_a = action_q.pop_front();
                    if (out_channel !== exp_a.ch)
                    begin
                        $display("%0t: out_channel expected %0d actual %0d",
                                 $time, exp_a.ch, out_channel);
                        n_errors++;
                    end
                    if (drive_write !== exp_a.pin.write)
                    begin
                        $display("%0t: ch %0d drive_write expected %0b actual %0b",
                                 $time, exp_a.ch, exp_a.pin.write, drive_write);
                        n_errors++;
                    end
                    if (drive_on !== exp_a.pin.on)
                    begin
                        $display("%0t: ch %0d drive_on expected %0b actual %0b",
                                 $time, exp_a.ch, exp_a.pin.on, drive_on);
                        n_errors++;
                    end
                end
            end
        end
    end

    // watchdog: too many cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic push_reading(input logic [7:0] ch, input logic ok,
                                input logic signed [15:0] temp,
                                input logic [31:0] now);
        reading_q.push_back({ch, ok, temp, now});
        n_items++;
    endtask

    // config write; block is idle so the predictor copy updates right away
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_OFF_THRESHOLD: threshold = val;
            REG_ON_SECONDS:    on_len    = val;
            REG_OFF_SECONDS:   off_len   = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // every reading gives one result, so matching counts means idle
    task automatic wait_drained();
        while (n_results != n_items)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // random readings, mostly near the threshold on a steadily running clock
    task automatic run_random(input int count);
        int       counted;
        int       step;
        int       t;
        reading_t r;
        counted = 0;
        step = (int'(on_len) + int'(off_len)) / 24 + 1;
        while (counted < count)
        begin
            // out-of-range channels now and then, a few busy channels often
            if ($urandom_range(99) < 6)
                r.ch = 8'($urandom_range(CHANNELS, 255));
            else if ($urandom_range(1))
                r.ch = 8'($urandom_range(3));
            else
                r.ch = 8'($urandom_range(CHANNELS - 1));
            r.ok = ($urandom_range(99) >= 8);
            if ($urandom_range(99) < 25)
            begin
                r.temp = 16'($urandom);
            end
            else
            begin
                t = int'($signed(threshold));
                t += int'($urandom_range(40)) - 8;
                if (t > 32767)
                    t = 32767;
                if (t < -32768)
                    t = -32768;
                r.temp = 16'(t);
            end
            if ($urandom_range(99) < 4)
            begin
                r.now = $urandom;
            end
            else
            begin
                clock_now += $urandom_range(step);
                r.now = clock_now;
            end
            push_reading(r.ch, r.ok, r.temp, r.now);
            if (r.ch < CHANNELS)
                counted++;
        end
    endtask

    initial
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            chan_phase[i] = PHASE_IDLE;
            chan_start[i] = '0;
            chan_on[i]    = 1'b0;
        end

        // thresholds and phase lengths, extremes included; mode picks idling
        settings[0] = '{16'($urandom), 16'd30,    16'd20,    32'd1000,      0};
        settings[1] = '{-16'sd32768,   16'd1,     16'd65535, 32'd50000,     0};
        settings[2] = '{16'sd32767,    16'd65535, 16'd1,     32'hFFFF_0000, 1};
        settings[3] = '{16'($urandom), 16'd0,     16'd0,     32'h0123_4567, 1};
        settings[4] = '{16'($urandom), 16'd45,    16'd60,    32'h8000_0000, 2};
        settings[5] = '{16'sd400,      16'd180,   16'd120,   32'hFFFF_F000, 2};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part on reset defaults: threshold 0, on 180 s, off 120 s
        push_reading(8'd16,  1'b1, 16'sd100,    32'd0);          // out of range
        push_reading(8'd255, 1'b1, 16'sd32767,  32'hFFFF_FFFF);  // out of range
        push_reading(8'd0,   1'b1, 16'sd0,      32'd10);         // at threshold: on
        push_reading(8'd0,   1'b1, 16'sd5,      32'd189);        // one short of on time
        push_reading(8'd0,   1'b1, 16'sd5,      32'd190);        // on time reached: off
        push_reading(8'd0,   1'b1, -16'sd1,     32'd400);        // cool while off: hold
        push_reading(8'd0,   1'b1, 16'sd32767,  32'd309);        // one short of off time
        push_reading(8'd0,   1'b1, 16'sd1,      32'd310);        // off time reached: on
        push_reading(8'd0,   1'b1, -16'sd32768, 32'd311);        // cool while on: off
        push_reading(8'd15,  1'b0, 16'sd0,      32'd0);          // missing reading
        push_reading(8'd15,  1'b1, 16'sd32767,  32'hFFFF_FFF0);  // on just before wrap
        push_reading(8'd15,  1'b1, 16'sd16,     32'h0000_00A3);  // wrapped, one short
        push_reading(8'd15,  1'b1, 16'sd16,     32'h0000_00A4);  // wrapped, off
        push_reading(8'd15,  1'b0, -16'sd32768, 32'd5);          // missing while off
        push_reading(8'd7,   1'b1, 16'sh5555,   32'hAAAA_AAAA);
        push_reading(8'd7,   1'b0, 16'shAAAA,   32'h5555_5555);
        push_reading(8'd3,   1'b1, -16'sd16,    32'd20);         // cool while idle
        push_reading(8'd3,   1'b1, 16'sd16,     32'd20);
        push_reading(8'd3,   1'b1, 16'sd0,      32'd200);
        push_reading(8'd3,   1'b0, 16'sd0,      32'd201);        // missing while off
        push_reading(8'd3,   1'b1, 16'sd0,      32'd202);        // idle again: on
        wait_drained();

        for (int s = 0; s < N_SETTINGS; s++)
        begin
            write_reg(REG_OFF_THRESHOLD, settings[s].thr);
            write_reg(REG_ON_SECONDS,    settings[s].on_len);
            write_reg(REG_OFF_SECONDS,   settings[s].off_len);
            clock_now = settings[s].t0;
            case (settings[s].mode)
                0:
                begin
                    src_idle_pct = 21;
                    snk_idle_pct = 79;
                end
                1:
                begin
                    src_idle_pct = 79;
                    snk_idle_pct = 21;
                end
                default:
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            run_random(75);
            // back-pressure: long receiver hold while the sender keeps going
            if (settings[s].mode == 2)
                pressure_req = 1'b1;
            wait_drained();
        end

        repeat (8) @(negedge clk);
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
